[design/yrn_pkg.sv]
// Package for the year to Roman numeral converter.
// Holds the micro-op encoding, the control ROM and the digit pattern helpers.
// No dependencies.
`timescale 1ns / 1ps

package yrn_pkg;

    localparam int YEAR_W  = 14;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int NDIG    = 4;
    localparam int SEL_W   = $clog2(NDIG);
    localparam int PC_W    = 4;
    localparam int QUO_W   = 11;
    localparam int PROD_W  = 27;

    // floor(x * DIV10_MUL / 2^16) == floor(x / 10) for every 14-bit x
    localparam logic [12:0] DIV10_MUL = 13'd6554;

    localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
    localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
    localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
    localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
    localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

    localparam logic [SEL_W-1:0] SEL_ONES = 2'd0;
    localparam logic [SEL_W-1:0] SEL_TENS = 2'd1;
    localparam logic [SEL_W-1:0] SEL_HUND = 2'd2;
    localparam logic [SEL_W-1:0] SEL_THOU = 2'd3;

    localparam logic [PC_W-1:0] PC_IDLE = 4'd0;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_DIV,
        OP_ZERO,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        SYM_UNIT,
        SYM_FIVE,
        SYM_TEN
    } t_sym;

    typedef struct packed {
        t_op               op;
        logic [SEL_W-1:0]  sel;
        logic              rep;
        logic [CHAR_W-1:0] unit;
        logic [CHAR_W-1:0] five;
        logic [CHAR_W-1:0] ten;
        logic [PC_W-1:0]   nxt;
    } t_uword;

    function automatic t_uword rom_word(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_WAIT, sel: SEL_ONES, rep: 1'b0, unit: CH_NONE, five: CH_NONE,
              ten: CH_NONE, nxt: PC_IDLE};
        case (pc)
            4'd0: begin
                w.op  = OP_WAIT;
                w.nxt = 4'd1;
            end
            4'd1: begin
                w.op  = OP_DIV;
                w.sel = SEL_ONES;
                w.nxt = 4'd2;
            end
            4'd2: begin
                w.op  = OP_DIV;
                w.sel = SEL_TENS;
                w.nxt = 4'd3;
            end
            4'd3: begin
                w.op  = OP_DIV;
                w.sel = SEL_HUND;
                w.nxt = 4'd4;
            end
            4'd4: begin
                w.op  = OP_DIV;
                w.sel = SEL_THOU;
                w.nxt = 4'd5;
            end
            4'd5: begin
                w.op  = OP_ZERO;
                w.nxt = 4'd6;
            end
            4'd6: begin
                w.op   = OP_EMIT;
                w.sel  = SEL_THOU;
                w.rep  = 1'b1;
                w.unit = CH_M;
                w.nxt  = 4'd7;
            end
            4'd7: begin
                w.op   = OP_EMIT;
                w.sel  = SEL_HUND;
                w.unit = CH_C;
                w.five = CH_D;
                w.ten  = CH_M;
                w.nxt  = 4'd8;
            end
            4'd8: begin
                w.op   = OP_EMIT;
                w.sel  = SEL_TENS;
                w.unit = CH_X;
                w.five = CH_L;
                w.ten  = CH_C;
                w.nxt  = 4'd9;
            end
            4'd9: begin
                w.op   = OP_EMIT;
                w.sel  = SEL_ONES;
                w.unit = CH_I;
                w.five = CH_V;
                w.ten  = CH_X;
                w.nxt  = PC_IDLE;
            end
            default: begin
                w.op  = OP_WAIT;
                w.nxt = PC_IDLE;
            end
        endcase
        return w;
    endfunction

    // number of characters a decimal digit produces
    function automatic logic [DIGIT_W-1:0] pat_len(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] n;
        if (d < 4'd4) begin
            n = d;
        end else if (d == 4'd4 || d >= 4'd9) begin
            n = 4'd2;
        end else begin
            n = 4'(d - 4'd4);
        end
        return n;
    endfunction

    // symbol at position k of a digit's pattern
    function automatic t_sym pat_sym(input logic [DIGIT_W-1:0] d, input logic [DIGIT_W-1:0] k);
        t_sym s;
        if (d < 4'd4) begin
            s = SYM_UNIT;
        end else if (d == 4'd4) begin
            s = (k == '0) ? SYM_UNIT : SYM_FIVE;
        end else if (d < 4'd9) begin
            s = (k == '0) ? SYM_FIVE : SYM_UNIT;
        end else begin
            s = (k == '0) ? SYM_UNIT : SYM_TEN;
        end
        return s;
    endfunction

endpackage

[design/year_to_roman_numeral.sv]
// Year to Roman numeral converter, top level.
// Microcoded sequencer over a divide-by-ten datapath; uses yrn_pkg.
`timescale 1ns / 1ps

// Takes one number per item (values above 9999 are taken modulo 10000) and
// returns its Roman numeral one ASCII character per output item, most
// significant first, with o_last_char on the final one; zero gives a single
// item with character code 0. A small control ROM steps a shared
// divide-by-ten unit four times, then walks the four digits through a repeat
// counter, holding while the output is stalled. A new item is taken only once
// the sequencer is back in its wait state: after the ones digit has been
// walked, or straight after the zero code has been loaded.
module year_to_roman_numeral (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [yrn_pkg::YEAR_W-1:0] i_year_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [yrn_pkg::CHAR_W-1:0] o_numeral_char,
    output logic                       o_last_char
);

    logic [yrn_pkg::PC_W-1:0]    r_pc, n_pc;
    logic [yrn_pkg::DIGIT_W-1:0] r_cnt, n_cnt;
    logic [yrn_pkg::YEAR_W-1:0]  r_val, n_val;
    logic [yrn_pkg::DIGIT_W-1:0] r_dig [yrn_pkg::NDIG];
    logic [yrn_pkg::DIGIT_W-1:0] n_dig [yrn_pkg::NDIG];
    logic                        r_out_valid, n_out_valid;
    logic [yrn_pkg::CHAR_W-1:0]  r_char, n_char;
    logic                        r_last, n_last;

    yrn_pkg::t_uword             w;
    logic [yrn_pkg::PROD_W-1:0]  prod;
    logic [yrn_pkg::QUO_W-1:0]   quo;
    logic [yrn_pkg::YEAR_W-1:0]  rem;
    logic [yrn_pkg::DIGIT_W-1:0] d;
    logic [yrn_pkg::DIGIT_W-1:0] len;
    logic                        can_emit;
    logic                        rest_zero;
    logic                        all_zero;
    yrn_pkg::t_sym               sym;

    assign w    = yrn_pkg::rom_word(r_pc);
    assign prod = yrn_pkg::PROD_W'(r_val) * yrn_pkg::PROD_W'(yrn_pkg::DIV10_MUL);
    assign quo  = prod[26:16];
    assign rem  = r_val - ({quo, 3'b000} + {2'b00, quo, 1'b0});

    assign d        = r_dig[w.sel];
    assign len      = w.rep ? d : yrn_pkg::pat_len(d);
    // thousands repeat the unit only
    assign sym      = w.rep ? yrn_pkg::SYM_UNIT : yrn_pkg::pat_sym(d, r_cnt);
    assign can_emit = !r_out_valid || i_ready;
    assign all_zero = (r_dig[0] == '0) && (r_dig[1] == '0) && (r_dig[2] == '0)
                      && (r_dig[3] == '0);

    always_comb begin
        rest_zero = 1'b1;
        for (int k = 0; k < yrn_pkg::NDIG; k++) begin
            if (yrn_pkg::SEL_W'(k) < w.sel && r_dig[k] != '0) begin
                rest_zero = 1'b0;
            end
        end
    end

    always_comb begin
        n_pc        = r_pc;
        n_cnt       = r_cnt;
        n_val       = r_val;
        n_dig       = r_dig;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (w.op)
            yrn_pkg::OP_WAIT: begin
                if (i_valid) begin
                    n_val = i_year_value;
                    n_cnt = '0;
                    n_pc  = w.nxt;
                end
            end
            yrn_pkg::OP_DIV: begin
                n_dig[w.sel] = rem[yrn_pkg::DIGIT_W-1:0];
                n_val        = yrn_pkg::YEAR_W'(quo);
                n_pc         = w.nxt;
            end
            yrn_pkg::OP_ZERO: begin
                if (!all_zero) begin
                    n_pc = w.nxt;
                end else if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_char      = yrn_pkg::CH_NONE;
                    n_last      = 1'b1;
                    n_pc        = yrn_pkg::PC_IDLE;
                end
            end
            yrn_pkg::OP_EMIT: begin
                if (len == '0) begin
                    n_cnt = '0;
                    n_pc  = w.nxt;
                end else if (can_emit) begin
                    n_out_valid = 1'b1;
                    case (sym)
                        yrn_pkg::SYM_UNIT: n_char = w.unit;
                        yrn_pkg::SYM_FIVE: n_char = w.five;
                        yrn_pkg::SYM_TEN:  n_char = w.ten;
                        default:           n_char = w.unit;
                    endcase
                    if (r_cnt == 4'(len - 4'd1)) begin
                        n_last = rest_zero;
                        n_cnt  = '0;
                        n_pc   = w.nxt;
                    end else begin
                        n_last = 1'b0;
                        n_cnt  = 4'(r_cnt + 4'd1);
                    end
                end
            end
            default: begin
                n_pc = yrn_pkg::PC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= yrn_pkg::PC_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_val  <= n_val;
        r_dig  <= n_dig;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_ready        = (w.op == yrn_pkg::OP_WAIT);
    assign o_valid        = r_out_valid;
    assign o_numeral_char = r_char;
    assign o_last_char    = r_last;

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_numeral_char == yrn_pkg::CH_NONE) |-> o_last_char)
        else $error("empty numeral not marked last");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while conversion starts");

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w.op == yrn_pkg::OP_EMIT || w.op == yrn_pkg::OP_ZERO) |->
        (r_dig[0] <= 4'd9 && r_dig[1] <= 4'd9 && r_dig[2] <= 4'd9 && r_dig[3] <= 4'd9))
        else $error("digit out of decimal range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w.op == yrn_pkg::OP_EMIT && len != '0) |-> (r_cnt < len))
        else $error("repeat counter past digit length");
`endif

endmodule
